FILE: rtl/icmp_sfe_pkg.sv
// ----------------------------------------------------------------------------
// icmp_sfe_pkg
// Shared types and constants for the ICMP scan feature extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package icmp_sfe_pkg;

  // counter widths
  localparam int COUNT_BITS_DEF  = 24;
  localparam int COUNT_BITS_MAX  = 32;
  localparam int OUT_BITS        = 24;
  localparam int SMALL_BITS      = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [OUT_BITS-1:0]   OUT_MAX   = '1;
  localparam logic [SMALL_BITS-1:0] SMALL_MAX = '1;

  // echo-like request types
  localparam logic [7:0] ICMP_ECHO      = 8'd8;
  localparam logic [7:0] ICMP_TIMESTAMP = 8'd13;
  localparam logic [7:0] ICMP_INFO      = 8'd15;
  localparam logic [7:0] ICMP_ADDR_MASK = 8'd17;
  localparam logic [7:0] ICMP_CODE_ZERO = 8'd0;

  // input beat
  typedef struct packed {
    logic [31:0] dest_ip;
    logic [7:0]  icmp_type;
    logic [7:0]  icmp_code;
    logic        last_flow;
  } flow_t;

  // result beat
  typedef struct packed {
    logic [OUT_BITS-1:0]   max_subnet_run;
    logic [SMALL_BITS-1:0] max_address_run;
    logic [SMALL_BITS-1:0] max_addresses_in_subnet;
    logic [OUT_BITS-1:0]   echo_flows;
    logic [OUT_BITS-1:0]   flow_count;
  } result_t;

  // classified flow handed from front to back
  typedef struct packed {
    logic is_echo;
    logic have_prev;
    logic same_subnet;
    logic same_addr;
    logic addr_step;
    logic subnet_step;
    logic last;
  } flow_class_t;

endpackage

`default_nettype wire

FILE: rtl/icmp_sfe_front.sv
// ----------------------------------------------------------------------------
// icmp_sfe_front
// Accepts flows, compares each address against the previous one and emits
// a compact classification for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module icmp_sfe_front
  import icmp_sfe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire flow_t       flow,
  input  wire logic        q_full,
  output      logic        q_push,
  output      flow_class_t q_data
);

  logic [31:0] prev_address;
  logic        have_prev;
  logic [31:0] addr_diff;
  logic [23:0] subnet_diff;

  assign q_push = push && !q_full;

  // pairwise compares against the previous address
  assign addr_diff   = flow.dest_ip - prev_address;
  assign subnet_diff = flow.dest_ip[31:8] - prev_address[31:8];

  always_comb begin
    q_data.is_echo     = (flow.icmp_type == ICMP_ECHO || flow.icmp_type == ICMP_TIMESTAMP ||
                          flow.icmp_type == ICMP_INFO || flow.icmp_type == ICMP_ADDR_MASK) &&
                         (flow.icmp_code == ICMP_CODE_ZERO);
    q_data.have_prev   = have_prev;
    q_data.same_subnet = (subnet_diff == 24'd0);
    q_data.same_addr   = (addr_diff == 32'd0);
    q_data.addr_step   = (addr_diff == 32'd1);
    q_data.subnet_step = (subnet_diff == 24'd1);
    q_data.last        = flow.last_flow;
  end

  // previous-address tracking, cleared at the end of each event
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev    <= 1'b0;
      prev_address <= '0;
    end else if (q_push) begin
      prev_address <= flow.dest_ip;
      have_prev    <= !flow.last_flow;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/icmp_sfe_queue.sv
// ----------------------------------------------------------------------------
// icmp_sfe_queue
// Short FIFO of classified flows between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module icmp_sfe_queue
  import icmp_sfe_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire flow_class_t wr_data,
  output      logic        full,
  input  wire logic        rd_en,
  output      logic        rd_valid,
  output      flow_class_t rd_data
);

  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  flow_class_t         mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_wr;
  logic                do_rd;

  assign full     = (count == CNT_BITS'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // fill count stays in range
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(DEPTH))
    else $error("queue count out of range");

  // a write when not full always lands
  a_write_lands: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> (count == $past(count) + 1'b1))
    else $error("queue write lost");

  // no read from an empty queue
  a_read_valid: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !do_rd)
    else $error("queue read while empty");

endmodule

`default_nettype wire

FILE: rtl/icmp_sfe_back.sv
// ----------------------------------------------------------------------------
// icmp_sfe_back
// Updates run, count and maximum state from classified flows and holds the
// event result until it is popped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module icmp_sfe_back
  import icmp_sfe_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire flow_class_t q_data,
  output      logic        q_pop,
  input  wire logic        pop,
  output      logic        empty,
  output      result_t     result
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [SMALL_BITS-1:0] SMALL_ONE = SMALL_BITS'(1);

  logic [SMALL_BITS-1:0] address_run, address_run_next;
  logic [SMALL_BITS-1:0] best_address_run, best_address_run_next;
  logic [SMALL_BITS-1:0] subnet_address_count, subnet_address_count_next;
  logic [SMALL_BITS-1:0] best_subnet_address_count, best_subnet_address_count_next;
  logic [COUNT_BITS-1:0] subnet_run, subnet_run_next;
  logic [COUNT_BITS-1:0] best_subnet_run, best_subnet_run_next;
  logic [COUNT_BITS-1:0] echo_count, echo_count_next;
  logic [COUNT_BITS-1:0] flows_seen, flows_seen_next;

  logic    out_valid;
  result_t out_data;
  result_t res_next;

  // clamp a counter to the result field width
  function automatic logic [OUT_BITS-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS_MAX-1:0] wide;
    wide = COUNT_BITS_MAX'(v);
    return (wide > COUNT_BITS_MAX'(OUT_MAX)) ? OUT_MAX : wide[OUT_BITS-1:0];
  endfunction

  // take a beat unless it is a last flow and the result slot stays busy
  assign q_pop  = q_valid && (!q_data.last || !out_valid || pop);
  assign empty  = !out_valid;
  assign result = out_data;

  // per-flow state update
  always_comb begin
    address_run_next               = address_run;
    best_address_run_next          = best_address_run;
    subnet_address_count_next      = subnet_address_count;
    best_subnet_address_count_next = best_subnet_address_count;
    subnet_run_next                = subnet_run;
    best_subnet_run_next           = best_subnet_run;

    flows_seen_next = (flows_seen == COUNT_MAX) ? COUNT_MAX : flows_seen + COUNT_ONE;
    echo_count_next = echo_count;
    if (q_data.is_echo && echo_count != COUNT_MAX) begin
      echo_count_next = echo_count + COUNT_ONE;
    end

    if (q_data.have_prev) begin
      if (q_data.same_subnet) begin
        if (!q_data.same_addr) begin
          if (subnet_address_count != SMALL_MAX) begin
            subnet_address_count_next = subnet_address_count + SMALL_ONE;
          end
          if (q_data.addr_step) begin
            if (address_run != SMALL_MAX) begin
              address_run_next = address_run + SMALL_ONE;
            end
          end else begin
            if (address_run > best_address_run) best_address_run_next = address_run;
            address_run_next = SMALL_ONE;
          end
        end
      end else begin
        // subnet change: fold address run and distinct count
        if (q_data.subnet_step) begin
          if (subnet_run != COUNT_MAX) subnet_run_next = subnet_run + COUNT_ONE;
        end else begin
          if (subnet_run > best_subnet_run) best_subnet_run_next = subnet_run;
          subnet_run_next = COUNT_ONE;
        end
        if (address_run > best_address_run) best_address_run_next = address_run;
        address_run_next = SMALL_ONE;
        if (subnet_address_count > best_subnet_address_count) begin
          best_subnet_address_count_next = subnet_address_count;
        end
        subnet_address_count_next = SMALL_ONE;
      end
    end

    // final fold for the result
    res_next.max_subnet_run = clamp_out((subnet_run_next > best_subnet_run_next) ?
                                        subnet_run_next : best_subnet_run_next);
    res_next.max_address_run = (address_run_next > best_address_run_next) ?
                               address_run_next : best_address_run_next;
    res_next.max_addresses_in_subnet =
      (subnet_address_count_next > best_subnet_address_count_next) ?
      subnet_address_count_next : best_subnet_address_count_next;
    res_next.echo_flows = clamp_out(echo_count_next);
    res_next.flow_count = clamp_out(flows_seen_next);
  end

  // feature state, back to reset values after each event
  always_ff @(posedge clk) begin
    if (rst || (q_pop && q_data.last)) begin
      address_run               <= SMALL_ONE;
      best_address_run          <= SMALL_ONE;
      subnet_address_count      <= SMALL_ONE;
      best_subnet_address_count <= SMALL_ONE;
      subnet_run                <= COUNT_ONE;
      best_subnet_run           <= COUNT_ONE;
      echo_count                <= '0;
      flows_seen                <= '0;
    end else if (q_pop) begin
      address_run               <= address_run_next;
      best_address_run          <= best_address_run_next;
      subnet_address_count      <= subnet_address_count_next;
      best_subnet_address_count <= best_subnet_address_count_next;
      subnet_run                <= subnet_run_next;
      best_subnet_run           <= best_subnet_run_next;
      echo_count                <= echo_count_next;
      flows_seen                <= flows_seen_next;
    end
  end

  // result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && q_data.last) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_data.last) begin
      out_data <= res_next;
    end
  end

  // a last flow always produces a waiting result
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_data.last) |=> out_valid)
    else $error("last flow did not produce a result");

  // state is cleared after the last flow of an event
  a_event_cleared: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_data.last) |=> (flows_seen == '0 && echo_count == '0))
    else $error("event state not cleared");

  // an unpopped result is never replaced
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> (out_valid && out_data == $past(out_data)))
    else $error("waiting result lost or overwritten");

  // run and count registers never drop below one
  a_runs_nonzero: assert property (@(posedge clk) disable iff (rst)
    (address_run != '0) && (subnet_address_count != '0) && (subnet_run != '0))
    else $error("run counter reached zero");

endmodule

`default_nettype wire

FILE: rtl/icmp_scan_feature_extractor_core.sv
// ----------------------------------------------------------------------------
// icmp_scan_feature_extractor_core
// Extracts scan features (subnet runs, address runs, distinct addresses per
// /24, echo-like requests, flows) from one ICMP event of sorted flows.
//
//   channel  dir  handshake         beat
//   flow     in   push / full       dest_ip, icmp_type, icmp_code, last_flow
//   result   out  pop / empty       one feature set per event
//
// One flow is accepted per cycle while full is low; the front classifies it
// against the previous address in the accept cycle. The back updates counters
// as it pops each flow from the queue and registers a result on a last flow.
// A waiting result stalls the back only when the next event's last flow
// arrives; full rises once the flow queue (two entries by default) fills up.
// Reset (rst, synchronous) clears the queue, the result slot and all state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module icmp_scan_feature_extractor_core
  import icmp_sfe_pkg::*;
#(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  output      logic    full,
  input  wire flow_t   flow,
  input  wire logic    pop,
  output      logic    empty,
  output      result_t result
);

  logic        fq_push;
  flow_class_t fq_wr_data;
  logic        fq_valid;
  logic        fq_pop;
  flow_class_t fq_rd_data;

  // front: accept and classify
  icmp_sfe_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .flow   (flow),
    .q_full (full),
    .q_push (fq_push),
    .q_data (fq_wr_data)
  );

  // queue between front and back
  icmp_sfe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fq_push),
    .wr_data  (fq_wr_data),
    .full     (full),
    .rd_en    (fq_pop),
    .rd_valid (fq_valid),
    .rd_data  (fq_rd_data)
  );

  // back: counters and result slot
  icmp_sfe_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (fq_valid),
    .q_data  (fq_rd_data),
    .q_pop   (fq_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

`default_nettype wire

FILE: bench/icmp_sfe_checker.sv
// ----------------------------------------------------------------------------
// icmp_sfe_checker
// Watches the flow and result channels of the ICMP scan feature extractor,
// predicts each event's feature set from the accepted flows and compares
// every popped result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module icmp_sfe_checker
  import icmp_sfe_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  logic    full,
  input  flow_t   flow,
  input  logic    pop,
  input  logic    empty,
  input  result_t result,
  output int      errors,
  output int      outstanding
);

  localparam logic [31:0] SUBNET_MASK = 32'hFFFF_FF00;
  localparam logic [31:0] SUBNET_STEP = 32'h0000_0100;
  localparam logic [23:0] COUNT_TOP   = '1;

  // running feature state of the current event
  logic [31:0] last_ip;
  logic        seen_any;
  logic [7:0]  ip_run, best_ip_run;
  logic [7:0]  ips_in_subnet, best_ips_in_subnet;
  logic [23:0] net_run, best_net_run;
  logic [23:0] echo_total, flow_total;

  result_t features_q[$];
  int      mismatch_cnt;

  task automatic clear_features();
    last_ip            = '0;
    seen_any           = 1'b0;
    ip_run             = 8'd1;
    best_ip_run        = 8'd1;
    ips_in_subnet      = 8'd1;
    best_ips_in_subnet = 8'd1;
    net_run            = 24'd1;
    best_net_run       = 24'd1;
    echo_total         = '0;
    flow_total         = '0;
  endtask

  task automatic close_ip_run();
    if (ip_run > best_ip_run) best_ip_run = ip_run;
    ip_run = 8'd1;
  endtask

  task automatic close_subnet_count();
    if (ips_in_subnet > best_ips_in_subnet) best_ips_in_subnet = ips_in_subnet;
    ips_in_subnet = 8'd1;
  endtask

  task automatic close_net_run();
    if (net_run > best_net_run) best_net_run = net_run;
    net_run = 24'd1;
  endtask

  // fold one accepted flow into the event state; queue a feature set on last
  task automatic predict_features(input flow_t f);
    logic [31:0] net_prev, net_now;
    result_t     fs;
    if (flow_total != COUNT_TOP) flow_total++;
    if ((f.icmp_type inside {ICMP_ECHO, ICMP_TIMESTAMP, ICMP_INFO, ICMP_ADDR_MASK}) &&
        f.icmp_code == ICMP_CODE_ZERO) begin
      if (echo_total != COUNT_TOP) echo_total++;
    end
    if (seen_any) begin
      net_prev = last_ip & SUBNET_MASK;
      net_now  = f.dest_ip & SUBNET_MASK;
      if (net_prev == net_now) begin
        // same /24: repeats change nothing
        if (f.dest_ip != last_ip) begin
          if (ips_in_subnet != SMALL_MAX) ips_in_subnet++;
          if (f.dest_ip - last_ip == 32'd1) begin
            if (ip_run != SMALL_MAX) ip_run++;
          end else begin
            close_ip_run();
          end
        end
      end else begin
        // subnet change, wraps modulo 2^32
        if (net_now - net_prev == SUBNET_STEP) begin
          if (net_run != COUNT_TOP) net_run++;
        end else begin
          close_net_run();
        end
        close_ip_run();
        close_subnet_count();
      end
    end
    last_ip  = f.dest_ip;
    seen_any = 1'b1;
    if (f.last_flow) begin
      close_net_run();
      close_ip_run();
      close_subnet_count();
      fs.max_subnet_run          = best_net_run;
      fs.max_address_run         = best_ip_run;
      fs.max_addresses_in_subnet = best_ips_in_subnet;
      fs.echo_flows              = echo_total;
      fs.flow_count              = flow_total;
      features_q.push_back(fs);
      clear_features();
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  initial begin
    clear_features();
    mismatch_cnt = 0;
    errors       = 0;
    outstanding  = 0;
  end

  // compare popped results, then predict from the accepted flow
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_features();
      features_q.delete();
    end else begin
      if (pop && !empty) begin
        if (features_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, result);
          mismatch_cnt++;
        end else begin
          want = features_q.pop_front();
          check_field("max_subnet_run", 32'(want.max_subnet_run),
                      32'(result.max_subnet_run));
          check_field("max_address_run", 32'(want.max_address_run),
                      32'(result.max_address_run));
          check_field("max_addresses_in_subnet", 32'(want.max_addresses_in_subnet),
                      32'(result.max_addresses_in_subnet));
          check_field("echo_flows", 32'(want.echo_flows), 32'(result.echo_flows));
          check_field("flow_count", 32'(want.flow_count), 32'(result.flow_count));
        end
      end
      if (push && !full) predict_features(flow);
    end
    errors      <= mismatch_cnt;
    outstanding <= features_q.size();
  end

endmodule

FILE: bench/tb_icmp_scan_feature_extractor_core.sv
// ----------------------------------------------------------------------------
// tb_icmp_scan_feature_extractor_core
// Drives ICMP events into the scan feature extractor: a directed set of
// boundary events, a full /24 sweep, then random scans and noise under
// several idle/stall mixes and one long result hold-off. Checking is done
// by icmp_sfe_checker, instantiated beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_icmp_scan_feature_extractor_core;
  import icmp_sfe_pkg::*;

  localparam int          HOLD_CYCLES  = 64;
  localparam int          STALL_LIMIT  = 5000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          PHASE_FLOWS  = 240;
  localparam logic [31:0] NET_MASK     = 32'hFFFF_FF00;

  logic    clk;
  logic    rst;
  logic    push;
  logic    full;
  flow_t   flow;
  logic    pop;
  logic    empty;
  result_t result;

  int errors;
  int outstanding;

  int idle_pct;
  int stall_pct;
  bit hold_off;
  int held;
  int flows_sent;
  int events_sent;
  int quiet_cycles;

  icmp_scan_feature_extractor_core dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .flow   (flow),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

  icmp_sfe_checker chk (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .flow        (flow),
    .pop         (pop),
    .empty       (empty),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // one flow beat; push stays high afterwards unless the next call idles
  task automatic send_flow(input logic [31:0] ip, input logic [7:0] t, c,
                           input logic last);
    flow_t f;
    f.dest_ip   = ip;
    f.icmp_type = t;
    f.icmp_code = c;
    f.last_flow = last;
    while ($urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    flow <= f;
    do @(posedge clk); while (full);
    flows_sent++;
  endtask

  // one event: a sorted scan with random steps, or unsorted noise
  task automatic send_event(input int unsigned len, input bit noisy);
    logic [31:0] ip;
    logic [7:0]  t, c;
    logic [7:0]  echo_types [4];
    int unsigned r;
    echo_types = '{ICMP_ECHO, ICMP_TIMESTAMP, ICMP_INFO, ICMP_ADDR_MASK};
    ip = $urandom;
    if ($urandom_range(3) == 0) ip[7:4] = 4'hF;
    if ($urandom_range(15) == 0) ip[31:8] = 24'hFF_FFFF;
    for (int i = 0; i < len; i++) begin
      if (i != 0) begin
        r = $urandom_range(99);
        if (noisy || (r >= 84 && r < 92)) ip = $urandom;
        else if (r < 55) ip = ip + 32'd1;
        else if (r < 65) ip = ip + $urandom_range(2, 8);
        else if (r < 78) ip = ((ip & NET_MASK) + 32'h100) | ($urandom & 32'hFF);
        else if (r < 84) ip = ((ip & NET_MASK) + ($urandom_range(2, 4) << 8)) |
                              ($urandom & 32'hFF);
        // otherwise a repeated address
      end
      r = $urandom_range(99);
      if (r < 60) begin
        t = echo_types[$urandom_range(3)];
        c = ICMP_CODE_ZERO;
      end else if (r < 70) begin
        t = echo_types[$urandom_range(3)];
        c = 8'($urandom_range(1, 255));
      end else begin
        t = 8'($urandom);
        c = ($urandom_range(1) == 0) ? ICMP_CODE_ZERO : 8'($urandom);
      end
      send_flow(ip, t, c, i == len - 1);
    end
    events_sent++;
  endtask

  // result side: random stalls, plus one long hold-off under pressure
  initial begin
    pop  = 1'b0;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_off && held < HOLD_CYCLES) begin
        pop <= 1'b0;
        held++;
      end else begin
        pop <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [23:0] base;
    rst          = 1'b1;
    push         = 1'b0;
    flow         = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_off     = 1'b0;
    flows_sent   = 0;
    events_sent  = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single-flow events at the address and field extremes
    send_flow(32'h0000_0000, ICMP_ECHO, ICMP_CODE_ZERO, 1'b1);
    send_flow(32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1);
    // subnet step, address run, repeat, wrap to 0.0.0.0, gap, fall in address
    send_flow(32'hFFFF_FEFF, ICMP_TIMESTAMP, ICMP_CODE_ZERO, 1'b0);
    send_flow(32'hFFFF_FF00, ICMP_INFO, ICMP_CODE_ZERO, 1'b0);
    send_flow(32'hFFFF_FF01, ICMP_ADDR_MASK, ICMP_CODE_ZERO, 1'b0);
    send_flow(32'hFFFF_FF01, ICMP_ECHO, 8'd1, 1'b0);
    send_flow(32'h0000_0000, 8'd0, ICMP_CODE_ZERO, 1'b0);
    send_flow(32'h0000_0005, ICMP_ECHO, ICMP_CODE_ZERO, 1'b0);
    send_flow(32'h0000_0003, 8'd14, ICMP_CODE_ZERO, 1'b0);
    send_flow(32'h0000_0004, ICMP_ECHO, ICMP_CODE_ZERO, 1'b0);
    send_flow(32'h0000_0005, ICMP_ECHO, ICMP_CODE_ZERO, 1'b1);
    events_sent += 3;
    // fall in subnet, then a skipped subnet
    send_flow(32'h0A00_0100, ICMP_ECHO, ICMP_CODE_ZERO, 1'b0);
    send_flow(32'h0A00_0000, ICMP_ECHO, ICMP_CODE_ZERO, 1'b0);
    send_flow(32'h0A00_0200, 8'h7F, 8'h80, 1'b1);
    // last flow repeating the previous address
    send_flow(32'hC0A8_0101, ICMP_ECHO, ICMP_CODE_ZERO, 1'b0);
    send_flow(32'hC0A8_0101, ICMP_ECHO, ICMP_CODE_ZERO, 1'b1);
    events_sent += 2;

    // full /24 sweep: address run and per-subnet count saturate
    base = 24'($urandom);
    for (int i = 0; i < 256; i++) begin
      send_flow({base, 8'(i)}, ICMP_ECHO, ICMP_CODE_ZERO, i == 255);
    end
    events_sent++;

    // random events under each idle/stall mix
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 83; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 16; stall_pct = 16; end
      endcase
      while (flows_sent < (ph + 1) * PHASE_FLOWS + 272) begin
        send_event(($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12),
                   $urandom_range(9) < 2);
      end
    end

    // short events at full rate while results are held back
    idle_pct  = 0;
    stall_pct = 0;
    hold_off  = 1'b1;
    for (int i = 0; i < 30; i++) send_event($urandom_range(1, 3), 1'b0);
    hold_off = 1'b0;

    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d flows in %0d events: boundary cases, a /24 sweep, scans and noise",
             flows_sent, events_sent);
    $display("under four idle/stall mixes and a %0d-cycle result hold-off", HOLD_CYCLES);
    if (errors == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/icmp_sfe_pkg.sv
rtl/icmp_sfe_front.sv
rtl/icmp_sfe_queue.sv
rtl/icmp_sfe_back.sv
rtl/icmp_scan_feature_extractor_core.sv
bench/icmp_sfe_checker.sv
bench/tb_icmp_scan_feature_extractor_core.sv
